FILE: rtl/assert_macros.svh
// Assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, a, c)
`define ASSERT_NEXT(lbl, a, c)
`endif
`endif

FILE: rtl/bfha_pkg.sv
package bfha_pkg;
	localparam int ADDR_W = 48;
	localparam int SIZE_W = 33;
	localparam int LEN_W = 32;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;
	localparam logic [ADDR_W-1:0] HDR_BYTES = 48'd16;
	localparam logic REG_START = 1'b0;
	localparam logic REG_LENGTH = 1'b1;
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE = 1'b1;
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} blk_t;
endpackage

FILE: rtl/bfha_table.sv
// Sorted free table: one slot per cycle during scan, one slot shift per cycle.
module bfha_table #(
	parameter int ENTRIES = 16,
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic [IW-1:0] rd_idx,
	output bfha_pkg::blk_t rd_data,
	input  logic wr_en,
	input  logic [IW-1:0] wr_idx,
	input  bfha_pkg::blk_t wr_data,
	input  logic cnt_inc,
	input  logic cnt_dec,
	output logic [CW-1:0] count
);
	import bfha_pkg::*;
	blk_t mem [ENTRIES];
	logic [CW-1:0] count_q;
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end
	assign rd_data = mem[rd_idx];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end
	assign count = count_q;
endmodule

FILE: rtl/best_fit_heap_allocator_unit.sv
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, func, req_len, page_align, block_addr, block_size
// out     | output    | out_valid, out_stall, mem_addr, status
// cfg     | input     | psel, penable, pwrite, paddr, pwdata, prdata, pready
// A table scan visits one slot per cycle; each shift of an insert or remove moves one slot.
// Reset clears top region, table count and handshake state; no clearing pass.
// in_stall is high during a config write and from accept until the result moves to the
// output register; a result still waiting there holds the sequencer in S_DONE.
module best_fit_heap_allocator_unit #(
	parameter int FREE_ENTRIES = 16,
	parameter int GRANULE = 128,
	parameter int PAGE_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [31:0] req_len,
	input  logic page_align,
	input  logic [47:0] block_addr,
	input  logic [32:0] block_size,
	output logic out_valid,
	input  logic out_stall,
	output logic [47:0] mem_addr,
	output logic [1:0] status,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import bfha_pkg::*;
	`include "assert_macros.svh"
	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam int GB = $clog2(GRANULE);
	localparam int PB = $clog2(PAGE_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_REMOVE, S_REINS, S_TOP, S_GAP, S_GAPCHUNK,
		S_REL, S_INSSCAN, S_INSSHIFT, S_INSWR, S_DONE
	} state_t;

	state_t state_q;
	logic [47:0] start_q, top_addr_q, hdr_q, res_addr_q, ins_addr_q, gap_q, out_addr_q;
	logic [31:0] length_q;
	logic [32:0] top_rem_q, nb_q, ins_size_q, consume_q, sel_size_q;
	logic [CW-1:0] idx_q;
	logic [1:0] status_q, out_status_q;
	logic page_q, ok_q, after_gap_q, out_valid_q;

	blk_t rd_data, wr_data;
	logic [IW-1:0] rd_idx, wr_idx;
	logic wr_en, cnt_inc, cnt_dec, clear;
	logic [CW-1:0] count;

	bfha_table #(.ENTRIES(FREE_ENTRIES), .IW(IW), .CW(CW)) u_table (
		.clk, .arst_n, .clear, .rd_idx, .rd_data, .wr_en, .wr_idx, .wr_data,
		.cnt_inc, .cnt_dec, .count
	);

	logic cfg_wr;
	logic reg_sel;
	assign reg_sel = paddr[3];
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign clear = cfg_wr;
	always_comb begin
		if (reg_sel == REG_START) begin
			prdata = {16'd0, start_q};
		end else begin
			prdata = {32'd0, length_q};
		end
	end

	logic [33:0] nb_sum;
	logic [32:0] nb_calc;
	assign nb_sum = {2'd0, req_len} + 34'd16 + 34'(GRANULE - 1);
	assign nb_calc = {nb_sum[32:GB], {GB{1'b0}}};

	logic [47:0] consume_calc;
	assign consume_calc = {{(48-PB){1'b0}},
		PB'(PB'(PAGE_BYTES - 16) - top_addr_q[PB-1:0])};

	// shared compare/subtract unit
	logic [32:0] op_a, op_b;
	logic [33:0] diff;
	logic ge;
	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign ge = !diff[33];
	logic [33:0] top_sum;
	assign top_sum = {1'b0, top_rem_q} + {1'b0, ins_size_q};

	logic bad_ins;
	assign bad_ins = (ins_size_q == '0) || ins_size_q[32] || (ins_size_q[3:0] != 4'd0);

	always_comb begin
		op_a = top_rem_q;
		op_b = nb_q;
		case (state_q)
			S_SCAN: begin
				op_a = rd_data.size;
				op_b = nb_q;
			end
			S_INSSCAN: begin
				op_a = rd_data.size;
				op_b = ins_size_q;
			end
			S_GAP: begin
				op_a = top_rem_q;
				op_b = consume_q;
			end
			default: begin
				op_a = top_rem_q;
				op_b = nb_q;
			end
		endcase
	end

	always_comb begin
		rd_idx = idx_q[IW-1:0];
		wr_en = 1'b0;
		wr_idx = idx_q[IW-1:0];
		wr_data = rd_data;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		case (state_q)
			S_REMOVE: begin
				rd_idx = IW'(idx_q + 1'b1);
				if (CW'(idx_q + 1'b1) < count) begin
					wr_en = 1'b1;
				end else begin
					cnt_dec = 1'b1;
				end
			end
			S_INSSHIFT: begin
				rd_idx = IW'(idx_q - 1'b1);
				wr_en = 1'b1;
			end
			S_INSWR: begin
				wr_en = 1'b1;
				wr_data.addr = ins_addr_q;
				wr_data.size = ins_size_q;
				cnt_inc = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != S_IDLE) || cfg_wr;
	assign out_valid = out_valid_q;
	assign mem_addr = out_addr_q;
	assign status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= '0;
			length_q <= '0;
			top_addr_q <= '0;
			top_rem_q <= '0;
			out_valid_q <= 1'b0;
			out_addr_q <= '0;
			out_status_q <= ST_OK;
			idx_q <= '0;
			status_q <= ST_OK;
			res_addr_q <= '0;
			hdr_q <= '0;
			ins_addr_q <= '0;
			gap_q <= '0;
			nb_q <= '0;
			ins_size_q <= '0;
			consume_q <= '0;
			sel_size_q <= '0;
			page_q <= 1'b0;
			ok_q <= 1'b0;
			after_gap_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_addr_q <= res_addr_q;
				out_status_q <= status_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (reg_sel == REG_START) begin
					start_q <= pwdata[47:0];
					top_addr_q <= pwdata[47:0];
					top_rem_q <= {1'b0, length_q[31:PB], {PB{1'b0}}};
				end else begin
					length_q <= pwdata[31:0];
					top_addr_q <= start_q;
					top_rem_q <= {1'b0, pwdata[31:PB], {PB{1'b0}}};
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						res_addr_q <= '0;
						status_q <= ST_OK;
						idx_q <= '0;
						nb_q <= nb_calc;
						page_q <= page_align;
						after_gap_q <= 1'b0;
						if (func == FN_ALLOC) begin
							state_q <= page_align ? S_GAP : S_SCAN;
							consume_q <= consume_calc[32:0];
						end else if (block_addr == '0) begin
							state_q <= S_DONE;
						end else begin
							ins_addr_q <= block_addr - HDR_BYTES;
							ins_size_q <= block_size;
							state_q <= S_REL;
						end
					end
				end
				S_SCAN: begin
					if (idx_q >= count) begin
						state_q <= S_TOP;
					end else if (ge) begin
						hdr_q <= rd_data.addr;
						sel_size_q <= rd_data.size;
						res_addr_q <= rd_data.addr + HDR_BYTES;
						state_q <= S_REMOVE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REMOVE: begin
					if (CW'(idx_q + 1'b1) < count) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_REINS;
					end
				end
				S_REINS: begin
					if (sel_size_q != nb_q) begin
						ins_addr_q <= hdr_q + {15'd0, nb_q};
						ins_size_q <= sel_size_q - nb_q;
						idx_q <= '0;
						state_q <= S_INSSCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TOP: begin
					if (ge) begin
						res_addr_q <= top_addr_q + HDR_BYTES;
						top_rem_q <= diff[32:0];
						top_addr_q <= top_addr_q + {15'd0, nb_q};
						ok_q <= 1'b1;
					end else begin
						ok_q <= 1'b0;
						if (!after_gap_q) begin
							status_q <= ST_OOM;
						end
					end
					if (after_gap_q) begin
						ins_addr_q <= gap_q;
						ins_size_q <= consume_q;
						state_q <= S_GAPCHUNK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GAP: begin
					if (consume_q == '0) begin
						state_q <= S_TOP;
					end else if (ge) begin
						gap_q <= top_addr_q;
						top_rem_q <= diff[32:0];
						top_addr_q <= top_addr_q + {15'd0, consume_q};
						after_gap_q <= 1'b1;
						state_q <= S_TOP;
					end else begin
						status_q <= ST_OOM;
						state_q <= S_DONE;
					end
				end
				S_GAPCHUNK: begin
					if (!ok_q) begin
						status_q <= ST_OOM;
					end
					state_q <= S_REL;
				end
				S_REL: begin
					if (bad_ins) begin
						status_q <= ST_BAD;
						state_q <= S_DONE;
					end else if (ins_addr_q + {15'd0, ins_size_q} == top_addr_q) begin
						top_addr_q <= ins_addr_q;
						top_rem_q <= top_sum[33] ? '1 : top_sum[32:0];
						state_q <= S_DONE;
					end else begin
						idx_q <= '0;
						state_q <= S_INSSCAN;
					end
				end
				S_INSSCAN: begin
					if (count >= CW'(FREE_ENTRIES)) begin
						status_q <= ST_FULL;
						state_q <= S_DONE;
					end else if (idx_q < count && !ge) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						hdr_q <= {{(48-CW){1'b0}}, idx_q};
						idx_q <= count;
						state_q <= (count == idx_q) ? S_INSWR : S_INSSHIFT;
					end
				end
				S_INSSHIFT: begin
					idx_q <= idx_q - 1'b1;
					if (CW'(idx_q - 1'b1) == hdr_q[CW-1:0]) begin
						state_q <= S_INSWR;
					end
				end
				S_INSWR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mem_addr) && $stable(status))
	`ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(FREE_ENTRIES))
	`ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
endmodule
